FILE: src/fwpid_pkg.sv
// Shared constants, configuration types and register map of the four-wheel PID controller.
`default_nettype none

package fwpid_pkg;

   // Fixed lane count of the datapath and default sizing.
   localparam int LANES           = 4;
   localparam int WHEEL_COUNT_DEF = 4;
   localparam int SPEED_BITS_DEF  = 16;

   // Fixed-point formats.
   localparam int FRAC_BITS  = 8;
   localparam int GAIN_BITS  = 16;
   localparam int KEEP_BITS  = 16;
   localparam int KEEP_FRAC  = 15;
   localparam int LIMIT_BITS = 16;
   localparam int IACC_W     = LIMIT_BITS + FRAC_BITS;
   localparam int DACC_W     = 32;

   // Result queue.
   localparam int FIFO_DEPTH = 8;

   // Register port.
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;
   localparam int REG_SEL_LSB = 3;
   localparam int REG_IDX_W   = CSR_ADDR_W - REG_SEL_LSB;

   localparam logic [REG_IDX_W-1:0] REG_LOOP_ENABLE = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PROP_GAINS  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_INTEG_GAINS = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DERIV_GAINS = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_DERIV_KEEP  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_INTEG_LOW   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_INTEG_HIGH  = 3'd6;

   typedef struct packed {
      logic                         loop_enable;
      logic [CSR_DATA_W-1:0]        prop_gains;
      logic [CSR_DATA_W-1:0]        integ_gains;
      logic [CSR_DATA_W-1:0]        deriv_gains;
      logic signed [KEEP_BITS-1:0]  deriv_keep;
      logic signed [LIMIT_BITS-1:0] integ_low;
      logic signed [LIMIT_BITS-1:0] integ_high;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      loop_enable: 1'b0,
      prop_gains:  '0,
      integ_gains: '0,
      deriv_gains: '0,
      deriv_keep:  '0,
      integ_low:   16'sh8000,
      integ_high:  16'sh7fff
   };

   // Settings of one wheel, sliced out of the packed gain registers.
   typedef struct packed {
      logic                         enable;
      logic [GAIN_BITS-1:0]         kp;
      logic [GAIN_BITS-1:0]         ki;
      logic [GAIN_BITS-1:0]         kd;
      logic signed [KEEP_BITS-1:0]  keep;
      logic signed [LIMIT_BITS-1:0] integ_low;
      logic signed [LIMIT_BITS-1:0] integ_high;
   } lane_cfg_type;

endpackage

`default_nettype wire

FILE: src/fwpid_chan_if.sv
// Valid/ready channel interfaces for speed samples and drive results.
`default_nettype none

interface fwpid_req_if #(parameter int SPEED_BITS = fwpid_pkg::SPEED_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [SPEED_BITS-1:0] target_w0;
   logic signed [SPEED_BITS-1:0] target_w1;
   logic signed [SPEED_BITS-1:0] target_w2;
   logic signed [SPEED_BITS-1:0] target_w3;
   logic signed [SPEED_BITS-1:0] measured_w0;
   logic signed [SPEED_BITS-1:0] measured_w1;
   logic signed [SPEED_BITS-1:0] measured_w2;
   logic signed [SPEED_BITS-1:0] measured_w3;

   modport source (output valid, target_w0, target_w1, target_w2, target_w3,
                   measured_w0, measured_w1, measured_w2, measured_w3,
                   input ready);
   modport sink (input valid, target_w0, target_w1, target_w2, target_w3,
                 measured_w0, measured_w1, measured_w2, measured_w3,
                 output ready);
endinterface

interface fwpid_rsp_if #(parameter int SPEED_BITS = fwpid_pkg::SPEED_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [SPEED_BITS-1:0] drive_w0;
   logic signed [SPEED_BITS-1:0] drive_w1;
   logic signed [SPEED_BITS-1:0] drive_w2;
   logic signed [SPEED_BITS-1:0] drive_w3;

   modport source (output valid, drive_w0, drive_w1, drive_w2, drive_w3, input ready);
   modport sink (input valid, drive_w0, drive_w1, drive_w2, drive_w3, output ready);
endinterface

`default_nettype wire

FILE: src/fwpid_csr.sv
// Register bank with APB-style write and read access for the controller settings.
`default_nettype none

module fwpid_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fwpid_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [fwpid_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [fwpid_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready,
   output fwpid_pkg::cfg_type                cfg
);
   import fwpid_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic [REG_IDX_W-1:0]  reg_index;
   logic                  write_hit;

   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_ADDR_W-1:REG_SEL_LSB];
   assign write_hit = psel && penable && pwrite;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_hit) begin
         case (reg_index)
            REG_LOOP_ENABLE: cfg_in.loop_enable = pwdata[0];
            REG_PROP_GAINS:  cfg_in.prop_gains  = pwdata;
            REG_INTEG_GAINS: cfg_in.integ_gains = pwdata;
            REG_DERIV_GAINS: cfg_in.deriv_gains = pwdata;
            REG_DERIV_KEEP:  cfg_in.deriv_keep  = pwdata[KEEP_BITS-1:0];
            REG_INTEG_LOW:   cfg_in.integ_low   = pwdata[LIMIT_BITS-1:0];
            REG_INTEG_HIGH:  cfg_in.integ_high  = pwdata[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_index)
         REG_LOOP_ENABLE: prdata[0] = cfg_ff.loop_enable;
         REG_PROP_GAINS:  prdata = cfg_ff.prop_gains;
         REG_INTEG_GAINS: prdata = cfg_ff.integ_gains;
         REG_DERIV_GAINS: prdata = cfg_ff.deriv_gains;
         REG_DERIV_KEEP:  prdata[KEEP_BITS-1:0] = cfg_ff.deriv_keep;
         REG_INTEG_LOW:   prdata[LIMIT_BITS-1:0] = cfg_ff.integ_low;
         REG_INTEG_HIGH:  prdata[LIMIT_BITS-1:0] = cfg_ff.integ_high;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

FILE: src/fwpid_lane.sv
// One wheel's PID core: a four-stage pipeline holding that wheel's loop state.
`default_nettype none

module fwpid_lane #(
   parameter int SPEED_BITS = fwpid_pkg::SPEED_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [SPEED_BITS-1:0]  target,
   input  logic signed [SPEED_BITS-1:0]  measured,
   input  fwpid_pkg::lane_cfg_type       cfg,
   output logic                          out_valid,
   output logic signed [SPEED_BITS-1:0]  drive
);
   import fwpid_pkg::*;

   localparam int ERR_W   = SPEED_BITS + 1;
   localparam int ESUM_W  = SPEED_BITS + 2;
   localparam int GS_W    = GAIN_BITS + 1;
   localparam int KP_W    = GS_W + ERR_W;
   localparam int KI_W    = GS_W + ESUM_W;
   localparam int KD_W    = GS_W + ERR_W;
   localparam int ISUM_W  = KI_W + 1;
   localparam int KEEPD_W = KEEP_BITS + DACC_W;
   localparam int KSH_W   = KEEPD_W - KEEP_FRAC;
   localparam int DSUM_W  = ((KSH_W > KD_W) ? KSH_W : KD_W) + 1;
   localparam int SUM_W   = ((KP_W > DACC_W) ? KP_W : DACC_W) + 2;
   localparam int SH_W    = SUM_W - FRAC_BITS;
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

   // Stage 1: error, error sum and measurement step.
   logic                         v1_ff;
   logic signed [SPEED_BITS-1:0] tgt1_ff;
   logic signed [ERR_W-1:0]      err1_ff, err1_in;
   logic signed [ESUM_W-1:0]     esum1_ff, esum1_in;
   logic signed [ERR_W-1:0]      dm1_ff, dm1_in;
   logic signed [ERR_W-1:0]      prev_err_ff;
   logic signed [SPEED_BITS-1:0] prev_meas_ff;

   // Stage 2: gain products.
   logic                         v2_ff;
   logic signed [SPEED_BITS-1:0] tgt2_ff;
   logic signed [KP_W-1:0]       kp2_ff, kp2_in;
   logic signed [KI_W-1:0]       ki2_ff, ki2_in;
   logic signed [KD_W-1:0]       kd2_ff, kd2_in;

   // Stage 3: integrator and derivative filter state.
   logic                         v3_ff;
   logic signed [SPEED_BITS-1:0] tgt3_ff;
   logic signed [KP_W-1:0]       kp3_ff;
   logic signed [IACC_W-1:0]     integ_ff, integ_in;
   logic signed [DACC_W-1:0]     deriv_ff, deriv_in;
   logic signed [ISUM_W-1:0]     isum, ihi, ilo;
   logic signed [KEEPD_W-1:0]    keepd;
   logic signed [KSH_W-1:0]      ksh;
   logic signed [DSUM_W-1:0]     dsum, dmax, dmin;

   // Stage 4: output sum, rounding and saturation.
   logic                         v4_ff;
   logic signed [SPEED_BITS-1:0] drive_ff, drive_in;
   logic signed [SUM_W-1:0]      sum;
   logic signed [SH_W-1:0]       shv, smax, smin;

   always_comb begin
      err1_in  = {target[SPEED_BITS-1], target} - {measured[SPEED_BITS-1], measured};
      esum1_in = {err1_in[ERR_W-1], err1_in} + {prev_err_ff[ERR_W-1], prev_err_ff};
      dm1_in   = {measured[SPEED_BITS-1], measured}
               - {prev_meas_ff[SPEED_BITS-1], prev_meas_ff};
   end

   always_comb begin
      kp2_in = $signed({1'b0, cfg.kp}) * err1_ff;
      ki2_in = $signed({1'b0, cfg.ki}) * esum1_ff;
      kd2_in = $signed({1'b0, cfg.kd}) * dm1_ff;
   end

   // The clamps compare against limits scaled to the accumulator's fraction.
   always_comb begin
      isum = {{(ISUM_W-IACC_W){integ_ff[IACC_W-1]}}, integ_ff}
           + {ki2_ff[KI_W-1], ki2_ff};
      ihi  = {{(ISUM_W-IACC_W){cfg.integ_high[LIMIT_BITS-1]}}, cfg.integ_high,
              {FRAC_BITS{1'b0}}};
      ilo  = {{(ISUM_W-IACC_W){cfg.integ_low[LIMIT_BITS-1]}}, cfg.integ_low,
              {FRAC_BITS{1'b0}}};
      // Upper limit first: if crossed, sums above it get it, others get the lower one.
      if (isum > ihi) begin
         integ_in = ihi[IACC_W-1:0];
      end else if (isum < ilo) begin
         integ_in = ilo[IACC_W-1:0];
      end else begin
         integ_in = isum[IACC_W-1:0];
      end
   end

   always_comb begin
      keepd = cfg.keep * deriv_ff;
      ksh   = keepd[KEEPD_W-1:KEEP_FRAC];
      dsum  = {{(DSUM_W-KSH_W){ksh[KSH_W-1]}}, ksh}
            - {{(DSUM_W-KD_W){kd2_ff[KD_W-1]}}, kd2_ff};
      dmax  = {{(DSUM_W-DACC_W+1){1'b0}}, {(DACC_W-1){1'b1}}};
      dmin  = {{(DSUM_W-DACC_W+1){1'b1}}, {(DACC_W-1){1'b0}}};
      if (dsum > dmax) begin
         deriv_in = dmax[DACC_W-1:0];
      end else if (dsum < dmin) begin
         deriv_in = dmin[DACC_W-1:0];
      end else begin
         deriv_in = dsum[DACC_W-1:0];
      end
   end

   always_comb begin
      sum  = {{(SUM_W-KP_W){kp3_ff[KP_W-1]}}, kp3_ff}
           + {{(SUM_W-IACC_W){integ_ff[IACC_W-1]}}, integ_ff}
           + {{(SUM_W-DACC_W){deriv_ff[DACC_W-1]}}, deriv_ff}
           + ROUND_HALF;
      shv  = sum[SUM_W-1:FRAC_BITS];
      smax = {{(SH_W-SPEED_BITS+1){1'b0}}, {(SPEED_BITS-1){1'b1}}};
      smin = {{(SH_W-SPEED_BITS+1){1'b1}}, {(SPEED_BITS-1){1'b0}}};
      if (!cfg.enable) begin
         drive_in = tgt3_ff;
      end else if (shv > smax) begin
         drive_in = smax[SPEED_BITS-1:0];
      end else if (shv < smin) begin
         drive_in = smin[SPEED_BITS-1:0];
      end else begin
         drive_in = shv[SPEED_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         prev_err_ff  <= '0;
         prev_meas_ff <= '0;
         integ_ff     <= '0;
         deriv_ff     <= '0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         if (in_valid && cfg.enable) begin
            prev_err_ff  <= err1_in;
            prev_meas_ff <= measured;
         end
         if (v2_ff && cfg.enable) begin
            integ_ff <= integ_in;
            deriv_ff <= deriv_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         tgt1_ff  <= target;
         err1_ff  <= err1_in;
         esum1_ff <= esum1_in;
         dm1_ff   <= dm1_in;
      end
      if (v1_ff) begin
         tgt2_ff <= tgt1_ff;
         kp2_ff  <= kp2_in;
         ki2_ff  <= ki2_in;
         kd2_ff  <= kd2_in;
      end
      if (v2_ff) begin
         tgt3_ff <= tgt2_ff;
         kp3_ff  <= kp2_ff;
      end
      if (v3_ff) begin
         drive_ff <= drive_in;
      end
   end

   assign out_valid = v4_ff;
   assign drive     = drive_ff;

   // With the loop off, a sample must leave the filter state untouched.
   a_state_held: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !cfg.enable) |=> ($stable(integ_ff) && $stable(deriv_ff)))
      else $error("loop state changed while loop disabled");

   a_history_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid && !cfg.enable) |=> ($stable(prev_err_ff) && $stable(prev_meas_ff)))
      else $error("error history changed while loop disabled");

endmodule

`default_nettype wire

FILE: src/fwpid_merge.sv
// Merges the lane results into one drive word and queues it for the result channel.
`default_nettype none

module fwpid_merge #(
   parameter int SPEED_BITS = fwpid_pkg::SPEED_BITS_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_accept,
   input  logic [fwpid_pkg::LANES-1:0]                     lane_valid,
   input  logic signed [SPEED_BITS-1:0]                    lane_drive [fwpid_pkg::LANES],
   input  logic                                            out_ready,
   output logic                                            in_ready,
   output logic                                            out_valid,
   output logic [fwpid_pkg::LANES*SPEED_BITS-1:0]          out_data
);
   import fwpid_pkg::*;

   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int DATA_W = LANES * SPEED_BITS;

   logic [DATA_W-1:0] fifo_ff [FIFO_DEPTH];
   logic [DATA_W-1:0] packed_word;
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic              push, pop;

   // Lanes run in lockstep, so any valid lane marks a finished sample.
   assign push = |lane_valid;
   assign pop  = out_valid && out_ready;

   always_comb begin
      for (int w = 0; w < LANES; w++) begin
         packed_word[w*SPEED_BITS +: SPEED_BITS] = lane_drive[w];
      end
   end

   // Samples in the lanes plus queued results never exceed the queue depth,
   // so a finished sample always finds a free entry.
   always_comb begin
      fill_in = fill_ff + {{(CNT_W-1){1'b0}}, push} - {{(CNT_W-1){1'b0}}, pop};
      occ_in  = occ_ff + {{(CNT_W-1){1'b0}}, in_accept} - {{(CNT_W-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         occ_ff    <= '0;
      end else begin
         fill_ff <= fill_in;
         occ_ff  <= occ_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= packed_word;
      end
   end

   assign in_ready  = occ_ff < CNT_W'(FIFO_DEPTH);
   assign out_valid = fill_ff != '0;
   assign out_data  = fifo_ff[rd_ptr_ff];

   a_fill_le_occ: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= occ_ff)
      else $error("more queued results than accepted samples");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(FIFO_DEPTH))
      else $error("outstanding sample count beyond queue depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (fill_ff != CNT_W'(FIFO_DEPTH)))
      else $error("lane result arrived with the queue full");

endmodule

`default_nettype wire

FILE: src/four_wheel_pid_speed_controller.sv
// Top level of the four-wheel PID speed controller: registers, wheel lanes and result queue.
//
// Usage: each transfer on req_ch carries a target and a measured speed for every
// wheel; each produces exactly one transfer on rsp_ch with one drive value per wheel,
// in the order the samples came in. Settings are written through the csr_ port
// (64-bit registers at byte address 8*index) while no sample is outstanding.
// Every wheel has its own lane: a four-stage pipeline (error, gain products,
// integrator and derivative filter, sum with rounding and saturation).
// A result passes the four lane stages and the result queue before rsp_ch offers it.
// Throughput: one sample per cycle while req_ch is ready; the lanes take a new sample
// every cycle and the per-wheel state recurrence closes inside the filter stage.
// Finished results wait in an eight-entry queue, so req_ch stays ready while
// rsp_ch stalls until eight samples are outstanding; then req_ch ready drops
// until a result transfer frees an entry.
// Reset (synchronous, active high) clears the loop state of every wheel, empties
// the queue and restores the register defaults; no clearing pass is needed.
// With loop_enable low, targets pass straight through and all state is held.
// Wheels at or above WHEEL_COUNT have no lane and always report zero drive.
`default_nettype none

module four_wheel_pid_speed_controller #(
   parameter int WHEEL_COUNT = fwpid_pkg::WHEEL_COUNT_DEF,
   parameter int SPEED_BITS  = fwpid_pkg::SPEED_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   fwpid_req_if.sink                         req_ch,
   fwpid_rsp_if.source                       rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fwpid_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [fwpid_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [fwpid_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import fwpid_pkg::*;

   cfg_type                      cfg;
   logic                         req_accept;
   logic                         merge_in_ready;
   logic                         merge_out_valid;
   logic [LANES*SPEED_BITS-1:0]  merge_out_data;
   logic [LANES-1:0]             lane_valid;
   logic signed [SPEED_BITS-1:0] lane_drive [LANES];
   logic signed [SPEED_BITS-1:0] tgt_lanes  [LANES];
   logic signed [SPEED_BITS-1:0] meas_lanes [LANES];

   // Register bank.
   fwpid_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // A sample is taken when the requester offers one and the queue has room.
   assign req_ch.ready = merge_in_ready;
   assign req_accept   = req_ch.valid && merge_in_ready;

   assign tgt_lanes[0]  = req_ch.target_w0;
   assign tgt_lanes[1]  = req_ch.target_w1;
   assign tgt_lanes[2]  = req_ch.target_w2;
   assign tgt_lanes[3]  = req_ch.target_w3;
   assign meas_lanes[0] = req_ch.measured_w0;
   assign meas_lanes[1] = req_ch.measured_w1;
   assign meas_lanes[2] = req_ch.measured_w2;
   assign meas_lanes[3] = req_ch.measured_w3;

   // One lane per wheel in use; the gain registers hold wheel 0 in the low word.
   for (genvar w = 0; w < LANES; w++) begin : g_lane
      if (w < WHEEL_COUNT) begin : g_on
         lane_cfg_type lane_cfg;

         assign lane_cfg = '{
            enable:     cfg.loop_enable,
            kp:         cfg.prop_gains[GAIN_BITS*w +: GAIN_BITS],
            ki:         cfg.integ_gains[GAIN_BITS*w +: GAIN_BITS],
            kd:         cfg.deriv_gains[GAIN_BITS*w +: GAIN_BITS],
            keep:       cfg.deriv_keep,
            integ_low:  cfg.integ_low,
            integ_high: cfg.integ_high
         };

         fwpid_lane #(.SPEED_BITS(SPEED_BITS)) u_lane (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (req_accept),
            .target    (tgt_lanes[w]),
            .measured  (meas_lanes[w]),
            .cfg       (lane_cfg),
            .out_valid (lane_valid[w]),
            .drive     (lane_drive[w])
         );
      end else begin : g_off
         assign lane_valid[w] = 1'b0;
         assign lane_drive[w] = '0;
      end
   end

   // Merging stage and result queue.
   fwpid_merge #(.SPEED_BITS(SPEED_BITS)) u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (req_accept),
      .lane_valid (lane_valid),
      .lane_drive (lane_drive),
      .out_ready  (rsp_ch.ready),
      .in_ready   (merge_in_ready),
      .out_valid  (merge_out_valid),
      .out_data   (merge_out_data)
   );

   assign rsp_ch.valid    = merge_out_valid;
   assign rsp_ch.drive_w0 = merge_out_data[0*SPEED_BITS +: SPEED_BITS];
   assign rsp_ch.drive_w1 = merge_out_data[1*SPEED_BITS +: SPEED_BITS];
   assign rsp_ch.drive_w2 = merge_out_data[2*SPEED_BITS +: SPEED_BITS];
   assign rsp_ch.drive_w3 = merge_out_data[3*SPEED_BITS +: SPEED_BITS];

endmodule

`default_nettype wire

FILE: tb/sv/tb_four_wheel_pid_speed_controller.sv
// Testbench of the four-wheel PID speed controller with a built-in fixed-point loop predictor.
`default_nettype none

module tb_four_wheel_pid_speed_controller;
   timeunit 1ns;
   timeprecision 1ps;

   import fwpid_pkg::*;

   localparam int          CLK_PERIOD   = 10;
   localparam int          RESET_CYCLES = 6;
   // The slowest correct run stays well below this limit, which leaves a wide margin.
   localparam int unsigned CYCLE_LIMIT  = 300_000;
   localparam int          SB           = SPEED_BITS_DEF;
   localparam int          PHASE_COUNT  = 8;
   localparam int          PHASE_ITEMS  = 110;
   localparam int          HOLD_CYCLES  = 300;

   // Register slot that the block does not implement; writes to it must be ignored.
   localparam logic [REG_IDX_W-1:0] REG_SPARE = 7;

   localparam longint DACC_MAX  = 2147483647;
   localparam longint DACC_MIN  = -DACC_MAX - 1;
   localparam longint DRIVE_MAX = (longint'(1) << (SB - 1)) - 1;
   localparam longint DRIVE_MIN = -DRIVE_MAX - 1;

   // One speed sample for all wheels, wheel 0 in the lowest slice.
   typedef struct packed {
      logic [LANES-1:0][SB-1:0] target;
      logic [LANES-1:0][SB-1:0] measured;
   } sample_t;

   // Drive values of one result, wheel 0 in the lowest slice.
   typedef logic [LANES-1:0][SB-1:0] drive_set_t;

   logic clock = 1'b0;
   logic reset;

   fwpid_req_if #(.SPEED_BITS(SB)) req_ch ();
   fwpid_rsp_if #(.SPEED_BITS(SB)) rsp_ch ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   four_wheel_pid_speed_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Register copy and per-wheel loop state of the predictor. Everything here
   // advances only when a sample transfer is accepted or a register is written.
   cfg_type           loop_settings = CFG_RESET;
   int                integ_acc  [LANES] = '{default: 0};
   int                deriv_acc  [LANES] = '{default: 0};
   logic signed [16:0] last_error [LANES] = '{default: '0};
   logic signed [SB-1:0] last_speed [LANES] = '{default: '0};

   // Expected drive sets in the order their samples were accepted.
   drive_set_t drive_expect [$];
   int         mismatch_count = 0;

   // Pacing controls shared by the test tasks, the sender and the receiver.
   bit req_gaps     = 1'b1;
   bit rsp_gaps     = 1'b1;
   int hold_request = 0;

   // One step of the discrete PID on every wheel. With the loop disabled the
   // targets pass through and no state moves. Integral and derivative carry
   // eight fraction bits; the derivative filter product is floored by 15 bits
   // and the sum is rounded half up before saturation to the speed range.
   function automatic drive_set_t pid_step(input sample_t s);
      drive_set_t         result;
      logic signed [SB-1:0] tgt16;
      logic signed [SB-1:0] meas16;
      longint tgt, meas, err, integ, deriv, total, drive;
      longint kp, ki, kd, keep, lo, hi;
      result = '0;
      for (int w = 0; w < LANES; w++) begin
         tgt16  = s.target[w];
         meas16 = s.measured[w];
         if (!loop_settings.loop_enable) begin
            result[w] = tgt16;
         end else begin
            tgt  = tgt16;
            meas = meas16;
            err  = tgt - meas;
            kp   = loop_settings.prop_gains[GAIN_BITS*w +: GAIN_BITS];
            ki   = loop_settings.integ_gains[GAIN_BITS*w +: GAIN_BITS];
            kd   = loop_settings.deriv_gains[GAIN_BITS*w +: GAIN_BITS];
            keep = $signed(loop_settings.deriv_keep);
            lo   = $signed(loop_settings.integ_low);
            hi   = $signed(loop_settings.integ_high);
            lo   = lo * (1 << FRAC_BITS);
            hi   = hi * (1 << FRAC_BITS);

            // Trapezoidal integral. The upper clamp is tested first, so with crossed
            // limits a sum above the upper one takes it and any other sum the lower one.
            integ = integ_acc[w] + ki * (err + last_error[w]);
            if (integ > hi)
               integ = hi;
            else if (integ < lo)
               integ = lo;

            // Band-limited derivative on the measurement, saturated to 32 bits.
            deriv = (keep * deriv_acc[w]) >>> KEEP_FRAC;
            deriv = deriv - kd * (meas - last_speed[w]);
            if (deriv > DACC_MAX)
               deriv = DACC_MAX;
            else if (deriv < DACC_MIN)
               deriv = DACC_MIN;

            total = kp * err + integ + deriv;
            drive = (total + (1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (drive > DRIVE_MAX)
               drive = DRIVE_MAX;
            else if (drive < DRIVE_MIN)
               drive = DRIVE_MIN;
            result[w] = drive[SB-1:0];

            integ_acc[w]  = integ;
            deriv_acc[w]  = deriv;
            last_error[w] = err[16:0];
            last_speed[w] = meas16;
         end
      end
      return result;
   endfunction

   // Builds a sample in which wheel w gets tgt + w*step as target and
   // meas - w*step as measurement, so the wheels see related but distinct inputs.
   function automatic sample_t spread_sample(input int tgt, input int meas, input int step);
      sample_t s;
      for (int w = 0; w < LANES; w++) begin
         s.target[w]   = tgt + w * step;
         s.measured[w] = meas - w * step;
      end
      return s;
   endfunction

   // Random wheel speeds. Four in ten wheels track their target closely, as in a
   // running loop; the rest are full-range values, extremes or near zero.
   function automatic sample_t random_sample();
      sample_t s;
      int      t;
      for (int w = 0; w < LANES; w++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               t             = $urandom_range(0, 12000) - 6000;
               s.target[w]   = t;
               s.measured[w] = t + $urandom_range(0, 400) - 200;
            end
            4, 5, 6: begin
               s.target[w]   = $urandom;
               s.measured[w] = $urandom;
            end
            7: begin
               s.target[w]   = $urandom_range(0, 1) ? 32767 : -32768;
               s.measured[w] = $urandom_range(0, 1) ? 32767 : -32768;
            end
            default: begin
               s.target[w]   = $urandom_range(0, 16) - 8;
               s.measured[w] = $urandom_range(0, 16) - 8;
            end
         endcase
      end
      return s;
   endfunction

   function automatic logic [GAIN_BITS-1:0] random_gain();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom_range(0, 1024);
         default: return $urandom;
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.loop_enable = ($urandom_range(0, 5) != 0);
      c.prop_gains  = '0;
      c.integ_gains = '0;
      c.deriv_gains = '0;
      for (int w = 0; w < LANES; w++) begin
         c.prop_gains[GAIN_BITS*w +: GAIN_BITS]  = random_gain();
         c.integ_gains[GAIN_BITS*w +: GAIN_BITS] = random_gain();
         c.deriv_gains[GAIN_BITS*w +: GAIN_BITS] = random_gain();
      end
      case ($urandom_range(0, 4))
         0:       c.deriv_keep = 16'sh8000;
         1:       c.deriv_keep = 16'sh7fff;
         2:       c.deriv_keep = $urandom;
         default: c.deriv_keep = $urandom_range(16384, 32767);
      endcase
      case ($urandom_range(0, 4))
         0: begin
            c.integ_low  = 16'sh8000;
            c.integ_high = 16'sh7fff;
         end
         1: begin
            // Crossed limits.
            c.integ_low  = $urandom_range(0, 3000);
            c.integ_high = -$urandom_range(0, 3000);
         end
         2: begin
            c.integ_low  = $urandom;
            c.integ_high = $urandom;
         end
         default: begin
            c.integ_low  = -$urandom_range(0, 8000);
            c.integ_high = $urandom_range(0, 8000);
         end
      endcase
      return c;
   endfunction

   // Register write: setup cycle, access cycle held until pready, then the port
   // returns to idle. The predictor copy is updated once the block has taken
   // the value.
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, {REG_SEL_LSB{1'b0}}};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_LOOP_ENABLE: loop_settings.loop_enable = data[0];
         REG_PROP_GAINS:  loop_settings.prop_gains  = data;
         REG_INTEG_GAINS: loop_settings.integ_gains = data;
         REG_DERIV_GAINS: loop_settings.deriv_gains = data;
         REG_DERIV_KEEP:  loop_settings.deriv_keep  = data[KEEP_BITS-1:0];
         REG_INTEG_LOW:   loop_settings.integ_low   = data[LIMIT_BITS-1:0];
         REG_INTEG_HIGH:  loop_settings.integ_high  = data[LIMIT_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_settings(input cfg_type c);
      csr_write(REG_PROP_GAINS, c.prop_gains);
      csr_write(REG_INTEG_GAINS, c.integ_gains);
      csr_write(REG_DERIV_GAINS, c.deriv_gains);
      csr_write(REG_DERIV_KEEP, CSR_DATA_W'(c.deriv_keep));
      csr_write(REG_INTEG_LOW, CSR_DATA_W'(c.integ_low));
      csr_write(REG_INTEG_HIGH, CSR_DATA_W'(c.integ_high));
      csr_write(REG_LOOP_ENABLE, CSR_DATA_W'(c.loop_enable));
   endtask

   // Offers one sample, with an occasional idle burst in front of it, and
   // records its prediction once the transfer has taken place. Called and
   // returning at a rising edge; valid stays high for a back-to-back sample.
   task automatic send_sample(input sample_t s);
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.target_w0   <= s.target[0];
      req_ch.target_w1   <= s.target[1];
      req_ch.target_w2   <= s.target[2];
      req_ch.target_w3   <= s.target[3];
      req_ch.measured_w0 <= s.measured[0];
      req_ch.measured_w1 <= s.measured[1];
      req_ch.measured_w2 <= s.measured[2];
      req_ch.measured_w3 <= s.measured[3];
      do @(posedge clock); while (!req_ch.ready);
      drive_expect.push_back(pid_step(s));
   endtask

   // Drops valid and waits until every sample has produced its result. Each
   // sample yields exactly one result, so the block is then idle.
   task automatic await_idle();
      req_ch.valid <= 1'b0;
      while (drive_expect.size() != 0) @(posedge clock);
   endtask

   // After reset the loop is off: targets must come straight through.
   task automatic test_passthrough_after_reset();
      send_sample(spread_sample(32767, -32768, 0));
      send_sample(spread_sample(-32768, 32767, 0));
      send_sample(spread_sample(-1, 0, 1));
      await_idle();
   endtask

   // Distinct gains per wheel, full-range errors, rounding and a pure
   // measurement step whose derivative must oppose the motion.
   task automatic test_pid_extremes();
      csr_write(REG_PROP_GAINS,  {16'h0080, 16'h1000, 16'hffff, 16'h0100});
      csr_write(REG_INTEG_GAINS, {16'h0000, 16'h0040, 16'h0200, 16'h0010});
      csr_write(REG_DERIV_GAINS, {16'h0100, 16'h0000, 16'h0300, 16'h0040});
      csr_write(REG_DERIV_KEEP, 64'h6000);
      csr_write(REG_INTEG_LOW, -1000);
      csr_write(REG_INTEG_HIGH, 1000);
      csr_write(REG_LOOP_ENABLE, 64'h1);
      send_sample(spread_sample(32767, -32768, 0));
      send_sample(spread_sample(-32768, 32767, 0));
      send_sample(spread_sample(0, 0, 0));
      send_sample(spread_sample(1000, 900, 37));
      send_sample(spread_sample(1000, 1000, 0));
      send_sample(spread_sample(-500, 1200, -11));
      send_sample(spread_sample(-1, 0, 0));
      await_idle();
   endtask

   // Largest derivative gain with a negative unity keep factor: a full-scale
   // measurement swing pushes the filter past 32 bits in both directions.
   task automatic test_derivative_saturation();
      csr_write(REG_PROP_GAINS, '0);
      csr_write(REG_INTEG_GAINS, '0);
      csr_write(REG_DERIV_GAINS, '1);
      csr_write(REG_DERIV_KEEP, 64'h8000);
      send_sample(spread_sample(0, 32767, 0));
      send_sample(spread_sample(0, -32768, 0));
      send_sample(spread_sample(0, 32767, 0));
      send_sample(spread_sample(0, 0, 0));
      await_idle();
   endtask

   // Crossed clamps: a sum above the upper clamp takes it, any other sum the lower one.
   task automatic test_crossed_clamps();
      csr_write(REG_DERIV_GAINS, '0);
      csr_write(REG_DERIV_KEEP, '0);
      csr_write(REG_PROP_GAINS, {4{16'h0100}});
      csr_write(REG_INTEG_GAINS, {4{16'h0100}});
      csr_write(REG_INTEG_LOW, 300);
      csr_write(REG_INTEG_HIGH, -300);
      send_sample(spread_sample(100, 0, 0));
      send_sample(spread_sample(-100, 0, 0));
      send_sample(spread_sample(0, 0, 0));
      await_idle();
   endtask

   // Disabling freezes the loop state; only bit 0 of the enable register
   // counts, and a write to the unimplemented slot changes nothing.
   task automatic test_disable_holds_state();
      csr_write(REG_LOOP_ENABLE, 64'hffff_ffff_ffff_fffe);
      send_sample(spread_sample(1234, -4321, 5));
      send_sample(spread_sample(-32768, 32767, 0));
      await_idle();
      csr_write(REG_SPARE, '1);
      csr_write(REG_LOOP_ENABLE, 64'h1);
      send_sample(spread_sample(200, 150, 3));
      send_sample(spread_sample(200, 200, 0));
      await_idle();
   endtask

   // The receiver stops for a long stretch while samples keep coming, so the
   // result queue fills and the block must stall its input.
   task automatic test_result_backpressure();
      req_gaps     = 1'b0;
      hold_request = HOLD_CYCLES;
      repeat (40) send_sample(random_sample());
      await_idle();
      req_gaps = 1'b1;
   endtask

   // Random phases, each under fresh settings written while the block is idle.
   // The first two use fixed extremes; the last runs without any idling.
   task automatic test_random_phases();
      cfg_type c;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p == 0) begin
            c             = CFG_RESET;
            c.loop_enable = 1'b1;
            c.prop_gains  = '1;
            c.integ_gains = '1;
            c.deriv_gains = '1;
            c.deriv_keep  = 16'sh7fff;
         end else if (p == 1) begin
            c             = CFG_RESET;
            c.loop_enable = 1'b1;
            c.prop_gains  = {4{16'h0001}};
            c.integ_gains = {4{16'h0001}};
            c.deriv_gains = {4{16'h0001}};
            c.deriv_keep  = 16'sh8000;
            c.integ_low   = '0;
            c.integ_high  = '0;
         end else begin
            c = random_settings();
         end
         load_settings(c);
         if (p == PHASE_COUNT - 1) begin
            req_gaps = 1'b0;
            rsp_gaps = 1'b0;
         end else begin
            // Some phases run with no idling at all.
            req_gaps = ($urandom_range(0, 3) != 0);
            rsp_gaps = ($urandom_range(0, 3) != 0);
         end
         repeat (PHASE_ITEMS) send_sample(random_sample());
         await_idle();
      end
   endtask

   // Receiver pacing: ready is high except during random idle bursts and the
   // long hold that the backpressure test asks for.
   initial begin : rsp_pacing
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end else if (rsp_gaps && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // Every result transfer is compared with the oldest expectation, wheel by wheel.
   always @(posedge clock) begin : drive_checker
      drive_set_t want;
      drive_set_t got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.drive_w3, rsp_ch.drive_w2, rsp_ch.drive_w1, rsp_ch.drive_w0};
         if (drive_expect.size() == 0) begin
            $error("drive result transfer with no sample outstanding");
            mismatch_count++;
         end else begin
            want = drive_expect.pop_front();
            for (int w = 0; w < LANES; w++) begin
               if (got[w] !== want[w]) begin
                  $error("drive_w%0d: expected %0d, actual %0d", w,
                         $signed(want[w]), $signed(got[w]));
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : test_sequence
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.target_w0   <= '0;
      req_ch.target_w1   <= '0;
      req_ch.target_w2   <= '0;
      req_ch.target_w3   <= '0;
      req_ch.measured_w0 <= '0;
      req_ch.measured_w1 <= '0;
      req_ch.measured_w2 <= '0;
      req_ch.measured_w3 <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_passthrough_after_reset();
      test_pid_extremes();
      test_derivative_saturation();
      test_crossed_clamps();
      test_disable_holds_state();
      test_result_backpressure();
      test_random_phases();

      // Give a stray late result a chance to show up before judging.
      await_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
